@@ design/scrl_pkg.sv @@
// Types, constants and helper functions shared by the output layer evaluator.
package scrl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_QUANT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BIAS  = 3'd4;

  localparam logic [7:0]         CLIP_LEVEL_RST   = 8'd255;
  localparam logic [7:0]         OUTPUT_QUANT_RST = 8'd64;
  localparam logic [9:0]         EVAL_SCALE_RST   = 10'd400;
  localparam logic [14:0]        SCORE_LIMIT_RST  = 15'd31000;
  localparam logic signed [15:0] OUTPUT_BIAS_RST  = 16'sd0;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_PAIR   = 1'b1;

  localparam int SUM_W  = 48;
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int O_W    = 49;
  localparam int DIV_W  = 60;
  localparam int DEN_W  = 16;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  typedef struct packed {
    logic               cmd;
    logic [8:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] white_value;
    logic signed [15:0] black_value;
    logic               side_to_move;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [15:0] score;
  } result_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DEN_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic signed [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [7:0] clip_act(logic signed [15:0] v, logic [7:0] c);
    logic [7:0] r;
    if (v[15]) begin
      r = 8'd0;
    end else if (v[14:0] > {7'd0, c}) begin
      r = c;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ design/scrl_item_if.sv @@
// Handshake channel that carries one input word of the evaluator.
interface scrl_item_if;
  import scrl_pkg::*;

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/scrl_result_if.sv @@
// Handshake channel that carries one score word of the evaluator.
interface scrl_result_if;
  import scrl_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/scrl_ram.sv @@
// Generic single write port RAM with a registered read port.
module scrl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/scrl_mul.sv @@
// Shared signed multiplier with a registered product.
module scrl_mul (
  input  logic                                clk,
  input  logic signed [scrl_pkg::MUL_W-1:0]  a,
  input  logic signed [scrl_pkg::MUL_W-1:0]  b,
  output logic signed [scrl_pkg::PROD_W-1:0] p
);
  import scrl_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

@@ design/scrl_div.sv @@
// Radix-2 restoring divider for a signed dividend and a positive divisor, truncating.
module scrl_div (
  input  logic                clk,
  input  logic                rst,
  input  scrl_pkg::div_req_t  req,
  output scrl_pkg::div_rsp_t  rsp
);
  import scrl_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [DIV_W-1:0] mag;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_dif;
  logic [DIV_W-1:0] abs_in;

  assign rem_sh  = {rem, mag[DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, den};
  assign rem_dif = rem_sh - {1'b0, den};
  assign abs_in  = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[DIV_W-1];
      mag <= abs_in;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      rem <= fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      mag <= {mag[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = neg ? -$signed(mag) : $signed(mag);
endmodule

@@ design/screlu_output_layer_eval.sv @@
// Top level of the squared clipped ReLU output layer evaluator.
// A weight write leaves the block ready for the next word.
// An activation pair passes through the shared multiplier: two squares, two products.
// A pair marked last adds two 60-step divisions and a three-part scale product.
// Ready is high only between words; the score register lets the next word in while it waits.
// Synchronous reset restores the registers, clears the sum and position; weights stay undefined.
module screlu_output_layer_eval #(
  parameter int HIDDEN_SIZE = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  scrl_item_if.sink                           items,
  scrl_result_if.source                       results,
  input  logic                                cfg_we,
  input  logic [scrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scrl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scrl_pkg::*;

  localparam int POS_W = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
  localparam int IX_W  = (POS_W > 8) ? POS_W + 2 : 11;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_SQ_US   = 14'b00000000000010,
    ST_SQ_THEM = 14'b00000000000100,
    ST_PR_THEM = 14'b00000000001000,
    ST_PR_US   = 14'b00000000010000,
    ST_ACC     = 14'b00000000100000,
    ST_DEN     = 14'b00000001000000,
    ST_DIV1    = 14'b00000010000000,
    ST_SC_HI   = 14'b00000100000000,
    ST_SC_MID  = 14'b00001000000000,
    ST_SC_LO   = 14'b00010000000000,
    ST_SC_ACC  = 14'b00100000000000,
    ST_DIV2_ST = 14'b01000000000000,
    ST_DIV2    = 14'b10000000000000
  } state_t;

  state_t state;

  logic [7:0]         clip_level;
  logic [7:0]         output_quant;
  logic [9:0]         eval_scale;
  logic [14:0]        score_limit;
  logic signed [15:0] output_bias;

  logic [7:0]  qa;
  logic [7:0]  qb;
  logic [14:0] lim;

  logic [7:0]              us_c;
  logic [7:0]              them_c;
  logic                    last_q;
  logic [16:0]             sq_us;
  logic [SUM_W-1:0]        sum;
  logic [POS_W-1:0]        pos;
  logic [DEN_W-1:0]        den;
  logic signed [O_W-1:0]   o;
  logic signed [DIV_W-1:0] acc;
  logic signed [DIV_W-1:0] o_full;
  logic signed [DIV_W-1:0] lim_x;
  logic signed [DIV_W-1:0] sc_q;
  logic                    out_valid;
  logic signed [15:0]      out_score;

  logic                     accept;
  logic [IX_W-1:0]          idx_x;
  logic [IX_W-1:0]          idx_oth;
  logic                     we_own;
  logic                     we_oth;
  logic [15:0]              w_own;
  logic [15:0]              w_them;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] p;
  logic [SUM_W-1:0]         p_ext;
  logic                     out_free;
  logic                     out_load;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign qa  = (clip_level == 8'd0) ? 8'd1 : clip_level;
  assign qb  = (output_quant == 8'd0) ? 8'd1 : output_quant;
  assign lim = (score_limit == 15'd0) ? 15'd0 : score_limit - 15'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_level   <= CLIP_LEVEL_RST;
      output_quant <= OUTPUT_QUANT_RST;
      eval_scale   <= EVAL_SCALE_RST;
      score_limit  <= SCORE_LIMIT_RST;
      output_bias  <= OUTPUT_BIAS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LEVEL:   clip_level   <= cfg_data[7:0];
        CFG_OUTPUT_QUANT: output_quant <= cfg_data[7:0];
        CFG_EVAL_SCALE:   eval_scale   <= cfg_data[9:0];
        CFG_SCORE_LIMIT:  score_limit  <= cfg_data[14:0];
        CFG_OUTPUT_BIAS:  output_bias  <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  assign items.ready = (state == ST_IDLE);
  assign accept      = items.valid && items.ready;

  // Slots below the hidden size hold own-side weights, the next block the other side.
  assign idx_x   = IX_W'(items.payload.weight_index);
  assign idx_oth = idx_x - IX_W'(HIDDEN_SIZE);
  assign we_own  = accept && (items.payload.cmd == CMD_WEIGHT) && (idx_x < IX_W'(HIDDEN_SIZE));
  assign we_oth  = accept && (items.payload.cmd == CMD_WEIGHT) &&
                   (idx_x >= IX_W'(HIDDEN_SIZE)) && (idx_x < IX_W'(2 * HIDDEN_SIZE));

  scrl_ram #(.WIDTH(16), .DEPTH(HIDDEN_SIZE)) u_ram_own (
    .clk   (clk),
    .we    (we_own),
    .waddr (idx_x[POS_W-1:0]),
    .wdata (items.payload.weight_value),
    .raddr (pos),
    .rdata (w_own)
  );

  scrl_ram #(.WIDTH(16), .DEPTH(HIDDEN_SIZE)) u_ram_oth (
    .clk   (clk),
    .we    (we_oth),
    .waddr (idx_oth[POS_W-1:0]),
    .wdata (items.payload.weight_value),
    .raddr (pos),
    .rdata (w_them)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ_US: begin
        mul_a = $signed({10'd0, us_c});
        mul_b = $signed({10'd0, us_c});
      end
      ST_SQ_THEM: begin
        mul_a = $signed({10'd0, them_c});
        mul_b = $signed({10'd0, them_c});
      end
      ST_PR_THEM: begin
        mul_a = $signed({1'b0, p[16:0]});
        mul_b = $signed({{2{w_them[15]}}, w_them});
      end
      ST_PR_US: begin
        mul_a = $signed({1'b0, sq_us});
        mul_b = $signed({{2{w_own[15]}}, w_own});
      end
      ST_ACC: begin
        mul_a = $signed({10'd0, qa});
        mul_b = $signed({10'd0, qb});
      end
      ST_SC_HI: begin
        mul_a = $signed({o[O_W-1], o[O_W-1:32]});
        mul_b = $signed({8'd0, eval_scale});
      end
      ST_SC_MID: begin
        mul_a = $signed({2'd0, o[31:16]});
        mul_b = $signed({8'd0, eval_scale});
      end
      ST_SC_LO: begin
        mul_a = $signed({2'd0, o[15:0]});
        mul_b = $signed({8'd0, eval_scale});
      end
      default: ;
    endcase
  end

  scrl_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign p_ext = {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};

  always_comb begin
    div_req.start    = (state == ST_DEN) || (state == ST_DIV2_ST);
    div_req.dividend = (state == ST_DEN) ? $signed({{(DIV_W - SUM_W){sum[SUM_W-1]}}, sum}) : acc;
    div_req.divisor  = (state == ST_DEN) ? {8'd0, qa} : den;
  end

  scrl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign o_full = div_rsp.quotient + $signed({{(DIV_W - 16){output_bias[15]}}, output_bias});
  assign lim_x  = $signed({{(DIV_W - 15){1'b0}}, lim});

  always_comb begin
    if (div_rsp.quotient > lim_x) begin
      sc_q = lim_x;
    end else if (div_rsp.quotient < -lim_x) begin
      sc_q = -lim_x;
    end else begin
      sc_q = div_rsp.quotient;
    end
  end

  assign out_free = !out_valid || results.ready;
  assign out_load = (state == ST_DIV2) && !div_rsp.busy && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sum       <= '0;
      pos       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (items.payload.cmd == CMD_PAIR)) begin
            state <= ST_SQ_US;
          end
        end
        ST_SQ_US:   state <= ST_SQ_THEM;
        ST_SQ_THEM: state <= ST_PR_THEM;
        ST_PR_THEM: state <= ST_PR_US;
        ST_PR_US: begin
          sum   <= sum + p_ext;
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum <= sum + p_ext;
          pos <= (pos == POS_W'(HIDDEN_SIZE - 1)) ? '0 : pos + 1'b1;
          state <= last_q ? ST_DEN : ST_IDLE;
        end
        ST_DEN: begin
          sum   <= '0;
          pos   <= '0;
          state <= ST_DIV1;
        end
        ST_DIV1: begin
          if (!div_rsp.busy) begin
            state <= ST_SC_HI;
          end
        end
        ST_SC_HI:   state <= ST_SC_MID;
        ST_SC_MID:  state <= ST_SC_LO;
        ST_SC_LO:   state <= ST_SC_ACC;
        ST_SC_ACC:  state <= ST_DIV2_ST;
        ST_DIV2_ST: state <= ST_DIV2;
        ST_DIV2: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      us_c   <= clip_act(items.payload.side_to_move ? items.payload.black_value
                                                    : items.payload.white_value, qa);
      them_c <= clip_act(items.payload.side_to_move ? items.payload.white_value
                                                    : items.payload.black_value, qa);
      last_q <= items.payload.last;
    end
    if (state == ST_SQ_THEM) begin
      sq_us <= p[16:0];
    end
    if (state == ST_DEN) begin
      den <= p[DEN_W-1:0];
    end
    if (state == ST_DIV1) begin
      o <= o_full[O_W-1:0];
    end
    if (state == ST_SC_MID) begin
      acc <= $signed({{(DIV_W - PROD_W){p[PROD_W-1]}}, p});
    end
    if ((state == ST_SC_LO) || (state == ST_SC_ACC)) begin
      acc <= $signed({acc[DIV_W-17:0], 16'd0}) +
             $signed({{(DIV_W - PROD_W){p[PROD_W-1]}}, p});
    end
    if (out_load) begin
      out_score <= sc_q[15:0];
    end
  end

  assign results.valid         = out_valid;
  assign results.payload.score = out_score;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_idle_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEN) |=> (sum == '0) && (pos == '0))
    else $error("running sum not cleared after final pair");

  a_result_from_div2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DIV2))
    else $error("score word raised outside final division");
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the squared clipped ReLU output layer evaluator.
`timescale 1ns / 1ps

module testbench;
  import scrl_pkg::*;

  localparam int HIDDEN      = 256;
  localparam int STORE_DEPTH = 2 * HIDDEN;
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 1500;
  localparam int LIMIT       = 2000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scrl_item_if item_ch ();
  scrl_result_if result_ch ();

  screlu_output_layer_eval #(
    .HIDDEN_SIZE(HIDDEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(item_ch),
    .results(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [7:0] clip_cfg;
  logic [7:0] quant_cfg;
  logic [9:0] scale_cfg;
  logic [14:0] limit_cfg;
  logic signed [15:0] bias_cfg;
  logic signed [15:0] weight_mem [STORE_DEPTH];
  logic signed [47:0] run_sum;
  int elem_pos;
  logic signed [15:0] pending_scores [$];

  int src_idle_pct;
  int sink_idle_pct;
  int hold_requests;
  int holds_served;
  int stall_left;
  int failures;
  int cycle_count;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("screlu_output_layer_eval verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_scores.size() == 0) begin
        $error("score: expected none, actual %0d", result_ch.payload.score);
        failures++;
      end else begin
        want = pending_scores.pop_front();
        if (want !== result_ch.payload.score) begin
          $error("score: expected %0d, actual %0d", want, result_ch.payload.score);
          failures++;
        end
      end
    end
  end

  function automatic longint clip_eff();
    return (clip_cfg == 8'd0) ? 64'sd1 : longint'(clip_cfg);
  endfunction

  function automatic longint act_square(logic signed [15:0] v);
    longint a;
    a = longint'(v);
    if (a < 0) a = 0;
    if (a > clip_eff()) a = clip_eff();
    return a * a;
  endfunction

  task automatic accumulate_word(item_t w);
    logic signed [15:0] own_act;
    logic signed [15:0] other_act;
    longint qa, qb, lim, o, s;
    if (w.cmd == CMD_WEIGHT) begin
      weight_mem[w.weight_index] = w.weight_value;
    end else begin
      own_act = w.side_to_move ? w.black_value : w.white_value;
      other_act = w.side_to_move ? w.white_value : w.black_value;
      run_sum = run_sum + act_square(own_act) * longint'(weight_mem[elem_pos])
              + act_square(other_act) * longint'(weight_mem[elem_pos + HIDDEN]);
      elem_pos = (elem_pos + 1) % HIDDEN;
      if (w.last) begin
        qa = clip_eff();
        qb = (quant_cfg == 8'd0) ? 64'sd1 : longint'(quant_cfg);
        lim = ((limit_cfg == 15'd0) ? 64'sd1 : longint'(limit_cfg)) - 1;
        o = longint'(run_sum) / qa + longint'(bias_cfg);
        s = (o * longint'(scale_cfg)) / (qa * qb);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        pending_scores.push_back(16'(s));
        run_sum = '0;
        elem_pos = 0;
      end
    end
  endtask

  function automatic logic signed [15:0] rand_act();
    int ce;
    ce = int'(clip_eff());
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(ce + 1, 0));
      6: return -16'sd1 - 16'($urandom_range(40));
      7: return 16'($urandom);
      8: return 16'sd0;
      default: return 16'(ce);
    endcase
  endfunction

  function automatic item_t make_pair(logic signed [15:0] white, logic signed [15:0] black,
                                      logic stm, logic fin);
    item_t it;
    it.cmd = CMD_PAIR;
    it.weight_index = 9'($urandom);
    it.weight_value = 16'($urandom);
    it.white_value = white;
    it.black_value = black;
    it.side_to_move = stm;
    it.last = fin;
    return it;
  endfunction

  function automatic item_t make_weight(logic [8:0] idx, logic signed [15:0] val);
    item_t it;
    it.cmd = CMD_WEIGHT;
    it.weight_index = idx;
    it.weight_value = val;
    it.white_value = 16'($urandom);
    it.black_value = 16'($urandom);
    it.side_to_move = 1'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  task automatic send_word(item_t w);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.payload <= w;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    accumulate_word(w);
  endtask

  task automatic stop_sending();
    item_ch.valid <= 1'b0;
  endtask

  task automatic send_stream(int n);
    for (int i = 0; i < n; i++) begin
      send_word(make_pair(rand_act(), rand_act(), 1'($urandom), i == n - 1));
    end
  endtask

  task automatic settle_scores();
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] clip, logic [7:0] quant, logic [9:0] scale,
                              logic [14:0] limit, logic signed [15:0] bias);
    settle_scores();
    write_reg(CFG_CLIP_LEVEL, {8'd0, clip});
    write_reg(CFG_OUTPUT_QUANT, {8'd0, quant});
    write_reg(CFG_EVAL_SCALE, {6'd0, scale});
    write_reg(CFG_SCORE_LIMIT, {1'b0, limit});
    write_reg(CFG_OUTPUT_BIAS, bias);
    cfg_we <= 1'b0;
    clip_cfg = clip;
    quant_cfg = quant;
    scale_cfg = scale;
    limit_cfg = limit;
    bias_cfg = bias;
  endtask

  task automatic test_weight_load();
    logic signed [15:0] v;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      v = 16'($urandom);
      if (i == 0 || i == HIDDEN + 1) v = 16'sh7fff;
      if (i == 1 || i == HIDDEN) v = 16'sh8000;
      send_word(make_weight(9'(i), v));
    end
    stop_sending();
  endtask

  task automatic test_directed_pairs();
    // The own side at the first position has the largest positive weight and the
    // other side the most negative one, so these two words saturate both ways.
    send_word(make_pair(16'sd255, 16'sd0, 1'b0, 1'b1));
    send_word(make_pair(16'sd0, 16'sd255, 1'b0, 1'b1));
    send_word(make_pair(16'sd0, 16'sd255, 1'b1, 1'b1));
    send_word(make_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b1));
    send_word(make_pair(16'sh8000, 16'sh7fff, 1'b0, 1'b1));
    send_word(make_pair(-16'sd1, 16'sd256, 1'b0, 1'b0));
    send_word(make_pair(16'sd254, 16'sd1, 1'b1, 1'b1));
    send_word(make_pair(16'sd0, 16'sd0, 1'b0, 1'b1));
    send_word(make_weight(9'd2, 16'sh7fff));
    send_word(make_weight(9'd258, 16'sh8000));
    send_word(make_pair(16'sd128, 16'sd127, 1'b0, 1'b0));
    send_word(make_weight(9'd0, 16'sd1));
    send_word(make_pair(16'sd255, 16'sd255, 1'b1, 1'b0));
    send_word(make_pair(16'sd200, 16'sd50, 1'b0, 1'b1));
    send_word(make_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b1));
    send_word(make_pair(16'sh8000, 16'sh8000, 1'b0, 1'b1));
    stop_sending();
  endtask

  task automatic test_config_settings();
    logic [7:0] clips [8] = '{8'd1, 8'd255, 8'd255, 8'd1, 8'd0, 8'd17, 8'd200, 8'd255};
    logic [7:0] quants [8] = '{8'd1, 8'd255, 8'd1, 8'd255, 8'd0, 8'd3, 8'd64, 8'd64};
    logic [9:0] scales [8] = '{10'd1, 10'd1023, 10'd1023, 10'd1, 10'd400, 10'd1023, 10'd400,
                               10'd400};
    logic [14:0] limits [8] = '{15'd2, 15'd32767, 15'd32767, 15'd2, 15'd31000, 15'd0, 15'd1,
                                15'd31000};
    logic signed [15:0] biases [8] = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd100,
                                       16'sd0, 16'sd5, 16'sd0};
    for (int k = 0; k < 8; k++) begin
      apply_config(clips[k], quants[k], scales[k], limits[k], biases[k]);
      send_stream($urandom_range(2, 1));
      send_stream($urandom_range(2, 1));
      stop_sending();
    end
  endtask

  task automatic test_long_stream();
    send_stream(300);
    stop_sending();
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 30; i++) send_stream($urandom_range(2, 1));
    stop_sending();
  endtask

  task automatic test_random_phase(int src_pct, int sink_pct, int n_items);
    int sent;
    int len;
    int r;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    apply_config(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                 10'($urandom_range(1023, 1)), 15'($urandom_range(32767, 2)), 16'($urandom));
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 15) begin
        send_word(make_weight(9'($urandom), 16'($urandom)));
        sent++;
      end else if (r < 25) begin
        send_word(make_pair(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)));
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
        send_stream(len);
        sent += len;
      end
    end
    send_word(make_pair(rand_act(), rand_act(), 1'($urandom), 1'b1));
    stop_sending();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.payload = '0;
    clip_cfg = CLIP_LEVEL_RST;
    quant_cfg = OUTPUT_QUANT_RST;
    scale_cfg = EVAL_SCALE_RST;
    limit_cfg = SCORE_LIMIT_RST;
    bias_cfg = OUTPUT_BIAS_RST;
    run_sum = '0;
    elem_pos = 0;
    hold_requests = 0;
    src_idle_pct = 10;
    sink_idle_pct = 58;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_weight_load();
    test_directed_pairs();
    test_config_settings();
    test_long_stream();
    test_backpressure();
    test_random_phase(10, 58, 170);
    test_random_phase(58, 10, 170);
    test_random_phase(0, 0, 170);

    settle_scores();
    if (failures == 0 && pending_scores.size() == 0) begin
      $display("screlu_output_layer_eval verification clean");
    end else begin
      $display("screlu_output_layer_eval verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/scrl_pkg.sv
design/scrl_item_if.sv
design/scrl_result_if.sv
design/scrl_ram.sv
design/scrl_mul.sv
design/scrl_div.sv
design/screlu_output_layer_eval.sv
tb/sv/testbench.sv
